/* design/lcdkt_pkg.sv */
// Package for the parallel bus LCD and keypad terminal.
// Holds the item structs, the bus and link codes and the key table.
// No dependencies.
`default_nettype none
package lcdkt_pkg;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] led_bits;
    logic       powered;
    logic       lcd_on;
    logic       lcd_two_lines;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] row;
    logic [2:0] col;
  } key_hit_t;

  // Item kinds.
  localparam logic [2:0] KIND_CTRL = 3'd0;
  localparam logic [2:0] KIND_ADDR = 3'd1;
  localparam logic [2:0] KIND_OUT  = 3'd2;
  localparam logic [2:0] KIND_READ = 3'd3;
  localparam logic [2:0] KIND_LINK = 3'd4;

  // Control byte bits.
  localparam logic [7:0] WR_MASK = 8'h42;  // WR or CS0
  localparam logic [7:0] RD_MASK = 8'h41;  // RD or CS0
  localparam int         PWR_BIT = 7;

  // Bus addresses.
  localparam logic [1:0] ADDR_LCD_CMD  = 2'd0;
  localparam logic [1:0] ADDR_LED      = 2'd1;
  localparam logic [1:0] ADDR_LCD_DATA = 2'd2;
  localparam logic [1:0] ADDR_SCAN     = 2'd3;
  localparam logic [1:0] ADDR_RD_KEYS  = 2'd0;
  localparam logic [1:0] ADDR_RD_STAT  = 2'd1;
  localparam logic [1:0] ADDR_RD_DATA  = 2'd3;

  // Link filter codes.
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_IDLE = 8'd0;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Key table: character to matrix position.
  function automatic key_hit_t key_lookup(input logic [7:0] ch);
    key_hit_t k;
    k = '0;
    case (ch)
      8'h33: k = '{1'b1, 3'd0, 3'd0};  // '3'
      8'h36: k = '{1'b1, 3'd0, 3'd1};  // '6'
      8'h39: k = '{1'b1, 3'd0, 3'd2};  // '9'
      8'h2A: k = '{1'b1, 3'd0, 3'd3};  // '*'
      8'h32: k = '{1'b1, 3'd1, 3'd0};  // '2'
      8'h35: k = '{1'b1, 3'd1, 3'd1};  // '5'
      8'h38: k = '{1'b1, 3'd1, 3'd2};  // '8'
      8'h30: k = '{1'b1, 3'd1, 3'd3};  // '0'
      8'h08: k = '{1'b1, 3'd1, 3'd4};  // backspace
      8'h31: k = '{1'b1, 3'd2, 3'd0};  // '1'
      8'h34: k = '{1'b1, 3'd2, 3'd1};  // '4'
      8'h37: k = '{1'b1, 3'd2, 3'd2};  // '7'
      8'h2E: k = '{1'b1, 3'd2, 3'd3};  // '.'
      8'h0D: k = '{1'b1, 3'd2, 3'd4};  // enter
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* design/lcdkt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module lcdkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/parallel_bus_lcd_keypad_terminal.sv */
// Parallel bus terminal: character LCD controller, LED latch and key matrix.
// Each item's result is registered at the edge that accepts it, in the output register
// or, while that one waits, in the skid stage behind it; input stalls while both are full.
// An LCD data read also stalls input while the sequencer waits on the display RAM
// read port, whose data comes out of a register.
// Reset is synchronous; display RAM entries carry valid bits, so RAM contents read
// as zero after reset or clear-display without any clearing pass.
// Depends on lcdkt_pkg and lcdkt_ram.
`default_nettype none
module parallel_bus_lcd_keypad_terminal import lcdkt_pkg::*; #(
  parameter int DISPLAY_RAM_DEPTH = 128,
  parameter int SCAN_ROWS         = 3
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CW = $clog2(DISPLAY_RAM_DEPTH);
  localparam logic [CW-1:0] LAST_POS = CW'(DISPLAY_RAM_DEPTH - 1);

  // Sequencer states: idle, or waiting on the display RAM read port.
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RDWAIT = 1'b1;

  logic state_r, state_nxt;

  // Bus and terminal state.
  logic [7:0]    ctrl_prev_r, ctrl_prev_nxt;
  logic [7:0]    ctrl_now_r, ctrl_now_nxt;
  logic [1:0]    bus_address_r, bus_address_nxt;
  logic [7:0]    bus_out_byte_r, bus_out_byte_nxt;
  logic [7:0]    bus_in_byte_r, bus_in_byte_nxt;
  logic          power_seen_r, power_seen_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic          move_back_r, move_back_nxt;
  logic          display_enabled_r, display_enabled_nxt;
  logic          two_line_mode_r, two_line_mode_nxt;
  logic [7:0]    led_latch_r, led_latch_nxt;
  logic [7:0]    scan_select_r, scan_select_nxt;
  logic [7:0]    key_rows_r [SCAN_ROWS];
  logic [7:0]    key_rows_nxt [SCAN_ROWS];
  logic [7:0]    telnet_mode_r, telnet_mode_nxt;

  // Display RAM valid bits: an entry not yet written since the last clear reads zero.
  logic [DISPLAY_RAM_DEPTH-1:0] ram_valid_r, ram_valid_nxt;
  logic                         rd_valid_r, rd_valid_nxt;

  // Display RAM port.
  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;

  // Output register with a skid stage behind it.
  out_item_t out_r, skid_r, result;
  logic      out_valid_r, skid_valid_r;

  logic       accept, out_fire, eval, wr_fall, rd_fall;
  logic [7:0] key_resp;
  key_hit_t   kh;

  // Cursor positions wrap modulo the RAM depth; the set-address value is
  // at most seven bits, so a few compare-and-subtract steps reduce it.
  function automatic logic [CW-1:0] wrap_pos(input logic [6:0] p);
    logic [9:0] x;
    x = {3'b000, p};
    for (int k = 2; k >= 0; k--) begin
      if (x >= 10'(DISPLAY_RAM_DEPTH << k)) begin
        x = x - 10'(DISPLAY_RAM_DEPTH << k);
      end
    end
    return x[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] cursor_step(input logic [CW-1:0] c, input logic back);
    logic [CW-1:0] n;
    if (back) begin
      n = (c == '0) ? LAST_POS : c - CW'(1);
    end else begin
      n = (c == LAST_POS) ? '0 : c + CW'(1);
    end
    return n;
  endfunction

  assign accept    = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = (state_r == S_IDLE) && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Key matrix read: AND of the rows whose scan-select bit is low.
  always_comb begin
    key_resp = 8'hFF;
    for (int i = 0; i < SCAN_ROWS; i++) begin
      if (!scan_select_r[i]) begin
        key_resp = key_resp & key_rows_r[i];
      end
    end
  end

  assign kh = key_lookup(in_data.value);

  // Main next-state logic for one accepted item.
  always_comb begin
    state_nxt           = state_r;
    ctrl_prev_nxt       = ctrl_prev_r;
    ctrl_now_nxt        = ctrl_now_r;
    bus_address_nxt     = bus_address_r;
    bus_out_byte_nxt    = bus_out_byte_r;
    bus_in_byte_nxt     = bus_in_byte_r;
    power_seen_nxt      = power_seen_r;
    cursor_nxt          = cursor_r;
    move_back_nxt       = move_back_r;
    display_enabled_nxt = display_enabled_r;
    two_line_mode_nxt   = two_line_mode_r;
    led_latch_nxt       = led_latch_r;
    scan_select_nxt     = scan_select_r;
    telnet_mode_nxt     = telnet_mode_r;
    ram_valid_nxt       = ram_valid_r;
    rd_valid_nxt        = rd_valid_r;
    for (int i = 0; i < SCAN_ROWS; i++) begin
      key_rows_nxt[i] = key_rows_r[i];
    end
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    eval    = 1'b0;
    wr_fall = 1'b0;
    rd_fall = 1'b0;

    // The RAM word for an LCD data read arrives in the cycle after the read issue.
    if (state_r == S_RDWAIT) begin
      bus_in_byte_nxt = rd_valid_r ? ram_rdata : 8'h00;
      state_nxt       = S_IDLE;
    end

    if (accept) begin
      case (in_data.kind)
        KIND_CTRL: begin
          // Writing the same control byte again is not a transition.
          if (in_data.value != ctrl_now_r) begin
            ctrl_prev_nxt = ctrl_now_r;
            ctrl_now_nxt  = in_data.value;
            eval          = 1'b1;
          end
        end
        KIND_ADDR: begin
          bus_address_nxt = in_data.value[1:0];
          eval            = 1'b1;
        end
        KIND_OUT: begin
          bus_out_byte_nxt = in_data.value;
          eval             = 1'b1;
        end
        KIND_LINK: begin
          // Telnet command filter, then key press or release.
          if (in_data.value == TN_IAC) begin
            telnet_mode_nxt = TN_IAC;
          end else if (telnet_mode_r != TN_IDLE) begin
            if (telnet_mode_r == TN_IAC) begin
              if (in_data.value >= TN_WILL && in_data.value <= TN_DONT) begin
                telnet_mode_nxt = in_data.value;
              end else if (in_data.value == TN_SB) begin
                telnet_mode_nxt = TN_SB;
              end else begin
                telnet_mode_nxt = TN_IDLE;
              end
            end else if (telnet_mode_r != TN_SB) begin
              telnet_mode_nxt = TN_IDLE;
            end
          end else if (in_data.value < CH_SPACE && in_data.value != CH_BS &&
                       in_data.value != CH_CR) begin
            // Other control characters are dropped.
          end else if (kh.hit && (int'(kh.row) < SCAN_ROWS)) begin
            for (int i = 0; i < SCAN_ROWS; i++) begin
              if (i == int'(kh.row)) begin
                key_rows_nxt[i][kh.col] = 1'b0;
              end
            end
          end else begin
            for (int i = 0; i < SCAN_ROWS; i++) begin
              key_rows_nxt[i] = 8'hFF;
            end
          end
        end
        default: begin
        end
      endcase

      // Bus evaluation after a control, address or output-byte write.
      if (eval) begin
        power_seen_nxt = power_seen_r | ctrl_now_nxt[PWR_BIT];
        if (power_seen_nxt) begin
          wr_fall = ((ctrl_prev_nxt & WR_MASK) != 8'h00) && ((ctrl_now_nxt & WR_MASK) == 8'h00);
          rd_fall = ((ctrl_prev_nxt & RD_MASK) != 8'h00) && ((ctrl_now_nxt & RD_MASK) == 8'h00);
        end
        if (wr_fall) begin
          case (bus_address_nxt)
            ADDR_LCD_CMD: begin
              // The highest set bit selects the instruction.
              if (bus_out_byte_nxt[7]) begin
                cursor_nxt = wrap_pos(bus_out_byte_nxt[6:0]);
              end else if (bus_out_byte_nxt[6]) begin
                // Character generator address is not modeled.
              end else if (bus_out_byte_nxt[5]) begin
                two_line_mode_nxt = bus_out_byte_nxt[3];
              end else if (bus_out_byte_nxt[4]) begin
                // Cursor or display shift is not modeled.
              end else if (bus_out_byte_nxt[3]) begin
                display_enabled_nxt = bus_out_byte_nxt[2];
              end else if (bus_out_byte_nxt[2]) begin
                move_back_nxt = !bus_out_byte_nxt[1];
              end else if (bus_out_byte_nxt[1]) begin
                cursor_nxt = '0;
              end else if (bus_out_byte_nxt[0]) begin
                cursor_nxt    = '0;
                ram_valid_nxt = '0;
              end
            end
            ADDR_LED: begin
              led_latch_nxt = bus_out_byte_nxt;
            end
            ADDR_LCD_DATA: begin
              ram_we                  = 1'b1;
              ram_valid_nxt[cursor_r] = 1'b1;
              cursor_nxt              = cursor_step(cursor_r, move_back_r);
            end
            ADDR_SCAN: begin
              scan_select_nxt = bus_out_byte_nxt;
            end
            default: begin
            end
          endcase
        end else if (rd_fall) begin
          case (bus_address_nxt)
            ADDR_RD_KEYS: begin
              bus_in_byte_nxt = key_resp;
            end
            ADDR_RD_STAT: begin
              bus_in_byte_nxt = 8'(cursor_r);
            end
            ADDR_RD_DATA: begin
              ram_re       = 1'b1;
              rd_valid_nxt = ram_valid_r[cursor_r];
              cursor_nxt   = cursor_step(cursor_r, move_back_r);
              state_nxt    = S_RDWAIT;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Result of the accepted item reflects the state after its update.
  always_comb begin
    result.read_data     = (in_data.kind == KIND_READ) ? bus_in_byte_r : 8'h00;
    result.led_bits      = led_latch_nxt;
    result.powered       = power_seen_nxt;
    result.lcd_on        = display_enabled_nxt;
    result.lcd_two_lines = two_line_mode_nxt;
  end

  lcdkt_ram #(
    .WIDTH (8),
    .DEPTH (DISPLAY_RAM_DEPTH)
  ) u_display_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cursor_r),
    .wdata (bus_out_byte_nxt),
    .re    (ram_re),
    .raddr (cursor_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      ctrl_prev_r       <= 8'h00;
      ctrl_now_r        <= 8'h00;
      bus_address_r     <= 2'd0;
      bus_out_byte_r    <= 8'h00;
      bus_in_byte_r     <= 8'h00;
      power_seen_r      <= 1'b0;
      cursor_r          <= '0;
      move_back_r       <= 1'b0;
      display_enabled_r <= 1'b0;
      two_line_mode_r   <= 1'b0;
      led_latch_r       <= 8'h00;
      scan_select_r     <= 8'hFF;
      telnet_mode_r     <= TN_IDLE;
      ram_valid_r       <= '0;
      rd_valid_r        <= 1'b0;
      for (int i = 0; i < SCAN_ROWS; i++) begin
        key_rows_r[i] <= 8'hFF;
      end
    end else begin
      state_r           <= state_nxt;
      ctrl_prev_r       <= ctrl_prev_nxt;
      ctrl_now_r        <= ctrl_now_nxt;
      bus_address_r     <= bus_address_nxt;
      bus_out_byte_r    <= bus_out_byte_nxt;
      bus_in_byte_r     <= bus_in_byte_nxt;
      power_seen_r      <= power_seen_nxt;
      cursor_r          <= cursor_nxt;
      move_back_r       <= move_back_nxt;
      display_enabled_r <= display_enabled_nxt;
      two_line_mode_r   <= two_line_mode_nxt;
      led_latch_r       <= led_latch_nxt;
      scan_select_r     <= scan_select_nxt;
      telnet_mode_r     <= telnet_mode_nxt;
      ram_valid_r       <= ram_valid_nxt;
      rd_valid_r        <= rd_valid_nxt;
      for (int i = 0; i < SCAN_ROWS; i++) begin
        key_rows_r[i] <= key_rows_nxt[i];
      end
    end
  end

  // Output register and skid stage: a new item may be taken while the
  // previous result still waits at the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (out_valid_r && !out_ready) begin
        skid_r       <= result;
        skid_valid_r <= 1'b1;
      end else begin
        out_r       <= result;
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
